FILE: rtl/core/qpf_pkg.sv
// ----------------------------------------------------------------------------
// qpf_pkg
// Shared widths, constants and types of the quintic profile follower.
// ----------------------------------------------------------------------------
package qpf_pkg;
   localparam int POS_W    = 32;
   localparam int FRAC_W   = 16;
   localparam int POSF_W   = 8;
   localparam int TIME_W   = 16;
   localparam int GAIN_W   = 16;
   localparam int DRV_W    = 16;
   localparam int DLT_W    = 8;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd2621;
   localparam int REQ_W    = 104;
   localparam int RSP_W    = 56;

   // Operation codes of the shared serial unit
   typedef enum logic [1:0] {
      OP_DIV  = 2'd0,
      OP_MUL  = 2'd1,
      OP_SQRT = 2'd2
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } unit_ctl_type;
endpackage

FILE: rtl/core/quintic_profile_follower_top.sv
// ----------------------------------------------------------------------------
// quintic_profile_follower_top
// Quintic 3-4-5 motion profile follower with square-root feedback drive.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. The next request is taken
// only once the response register is free. A tick of a move that is still
// running walks seven operations in sequence on one shared bit-serial unit:
// divide, u^2, u^3, u^3 times the polynomial, span times fraction, square
// root of the error, gain times root. Each step launches the unit once and
// waits until it is no longer busy. Once the elapsed time has reached the
// duration the divide is skipped. A tick of a finished move uses no unit
// operation and returns the final position with the done flag set.
module quintic_profile_follower_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [qpf_pkg::GAIN_W-1:0] csr_data,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // current_pos[31:0], final_pos[63:32], move_duration[79:64],
   // tolerance[95:80], elapsed_delta[103:96]
   input  logic [qpf_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // drive[15:0], done_res[16], target_pos[48:17], zero[55:49]
   output logic [qpf_pkg::RSP_W-1:0]  rsp_tdata
);
   import qpf_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV, ST_U2, ST_U3, ST_POLY, ST_SPAN, ST_SQRT, ST_GAIN,
      ST_WAIT, ST_OUT
   } state_type;

   state_type          state_ff;
   logic [GAIN_W-1:0]  gain_ff;
   logic signed [POS_W-1:0] lfinal_ff, lstart_ff, cur_ff;
   logic [TIME_W-1:0]  ldur_ff, ltol_ff, elapsed_ff;
   logic               done_ff;
   logic [FRAC_W:0]    u_ff;
   logic [FRAC_W+1:0]  u2_ff, u3_ff, p_ff;
   logic signed [47:0] err_ff;
   logic signed [47:0] tq_ff;
   logic               rsp_valid_ff;
   logic [RSP_W-1:0]   rsp_ff;
   unit_ctl_type       ctl;
   logic [63:0]        opa, opb, ures;
   logic               ubusy;
   logic               fin_ff;

   qpf_serial_unit u_unit (
      .clock (clock), .reset (reset), .ctl (ctl), .opa (opa), .opb (opb),
      .busy (ubusy), .result (ures)
   );

   logic signed [POS_W-1:0] in_cur, in_fin;
   assign in_cur = req_tdata[31:0];
   assign in_fin = req_tdata[63:32];

   logic signed [POS_W:0] span, pos_gap;
   logic [POS_W:0]        span_mag, adist;
   assign span     = {lfinal_ff[POS_W-1], lfinal_ff} - {lstart_ff[POS_W-1], lstart_ff};
   assign span_mag = span[POS_W] ? -span : span;
   assign pos_gap  = {cur_ff[POS_W-1], cur_ff} - {lfinal_ff[POS_W-1], lfinal_ff};
   assign adist    = pos_gap[POS_W] ? -pos_gap : pos_gap;

   logic [47:0] err_mag;
   assign err_mag = err_ff[47] ? -err_ff : err_ff;

   // inner = 10 + 6u^2 - 15u, Q.16, always positive
   logic [FRAC_W+4:0] inner;
   assign inner = 21'(10 << FRAC_W) + 21'(u2_ff) * 21'd6 - 21'(u_ff) * 21'd15;

   logic [16:0] elapsed_sum;
   assign elapsed_sum = {1'b0, elapsed_ff} + 17'(req_tdata[103:96]);

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // Launch once per step, then wait for the unit
   logic ctl_hold, launched_ff;
   assign ctl_hold = launched_ff;

   // Unit command for the step being entered
   always_comb begin
      ctl.start = 1'b0;
      ctl.op    = OP_MUL;
      opa = '0;
      opb = '0;
      if (!ubusy && !ctl_hold) begin
         case (state_ff)
            ST_DIV: begin
               // skip the divide once the elapsed time reaches the duration
               if (elapsed_ff < ldur_ff) begin
                  ctl.start = 1'b1; ctl.op = OP_DIV;
                  opa = {32'd0, elapsed_ff, 16'd0}; opb = 64'(ldur_ff);
               end
            end
            ST_U2: begin
               ctl.start = 1'b1; opa = 64'(u_ff); opb = 64'(u_ff);
            end
            ST_U3: begin
               ctl.start = 1'b1; opa = 64'(u2_ff); opb = 64'(u_ff);
            end
            ST_POLY: begin
               ctl.start = 1'b1; opa = 64'(u3_ff); opb = 64'(inner);
            end
            ST_SPAN: begin
               ctl.start = 1'b1; opa = 64'(span_mag); opb = 64'(p_ff);
            end
            ST_SQRT: begin
               ctl.start = 1'b1; ctl.op = OP_SQRT; opa = 64'(err_mag);
            end
            ST_GAIN: begin
               ctl.start = 1'b1; opa = 64'(gain_ff); opb = ures;
            end
            default: ;
         endcase
      end
   end

   logic [63:0] pfull;
   assign pfull = ures >> FRAC_W;
   logic signed [47:0] delta;
   logic [47:0] part;
   assign part  = 48'(ures >> (FRAC_W - POSF_W));
   assign delta = span[POS_W] ? -part : part;
   logic [63:0] dm;
   assign dm = ures >> 5;
   logic [DRV_W-1:0] drive;
   always_comb begin
      if (err_ff[47])
         drive = (dm > 64'd32768) ? 16'h8000 : 16'(-dm);
      else if (err_ff != 48'sd0)
         drive = (dm > 64'd32767) ? 16'h7FFF : 16'(dm);
      else
         drive = '0;
   end

   // Sequencer, state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= GAIN_RESET;
         lfinal_ff    <= '0;
         lstart_ff    <= '0;
         ldur_ff      <= '0;
         ltol_ff      <= '0;
         elapsed_ff   <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         launched_ff  <= 1'b0;
         fin_ff       <= 1'b0;
      end else begin
         if (csr_valid) gain_ff <= csr_data;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         if (ctl.start) launched_ff <= 1'b1;
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && req_tready) begin
                  cur_ff <= in_cur;
                  if (in_fin != lfinal_ff) begin
                     lfinal_ff  <= in_fin;
                     lstart_ff  <= in_cur;
                     ldur_ff    <= req_tdata[79:64];
                     ltol_ff    <= req_tdata[95:80];
                     elapsed_ff <= '0;
                     done_ff    <= 1'b0;
                     state_ff   <= ST_DIV;
                  end else begin
                     elapsed_ff <= elapsed_sum[16] ? 16'hFFFF : elapsed_sum[15:0];
                     state_ff   <= done_ff ? ST_OUT : ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               if (elapsed_ff >= ldur_ff) begin
                  u_ff     <= 17'h10000;
                  state_ff <= ST_U2;
               end else if (launched_ff && !ubusy) begin
                  u_ff <= 17'(ures); launched_ff <= 1'b0; state_ff <= ST_U2;
               end
            end
            ST_U2: if (launched_ff && !ubusy) begin
               u2_ff <= 18'(ures >> FRAC_W); launched_ff <= 1'b0; state_ff <= ST_U3;
            end
            ST_U3: if (launched_ff && !ubusy) begin
               u3_ff <= 18'(ures >> FRAC_W); launched_ff <= 1'b0; state_ff <= ST_POLY;
            end
            ST_POLY: if (launched_ff && !ubusy) begin
               p_ff <= (pfull > 64'h10000) ? 18'h10000 : 18'(pfull);
               launched_ff <= 1'b0; state_ff <= ST_SPAN;
            end
            ST_SPAN: if (launched_ff && !ubusy) begin
               tq_ff  <= (48'(signed'(lstart_ff)) <<< POSF_W) + delta;
               err_ff <= (48'(signed'(lstart_ff)) <<< POSF_W) + delta
                         - (48'(signed'(cur_ff)) <<< POSF_W);
               launched_ff <= 1'b0; state_ff <= ST_SQRT;
            end
            ST_SQRT: if (launched_ff && !ubusy) begin
               launched_ff <= 1'b0; state_ff <= ST_GAIN;
            end
            ST_GAIN: if (launched_ff && !ubusy) begin
               launched_ff <= 1'b0; state_ff <= ST_WAIT;
               fin_ff <= (elapsed_ff >= ldur_ff) || (adist < 33'(ltol_ff));
            end
            ST_WAIT: begin
               rsp_ff <= {7'd0, tq_ff[POSF_W +: POS_W], fin_ff, drive};
               done_ff <= fin_ff;
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            ST_OUT: begin
               rsp_ff <= {7'd0, lfinal_ff, 1'b1, 16'd0};
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // A response is never overwritten before it is taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("response lost");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff != ST_WAIT && state_ff != ST_OUT)
      else $error("response register busy");
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !ubusy)
      else $error("unit busy while idle");
endmodule

FILE: rtl/core/qpf_serial_unit.sv
// ----------------------------------------------------------------------------
// qpf_serial_unit
// Shared bit-serial unit: unsigned multiply (shift-add), restoring divide and
// integer square root, one bit or one root digit per cycle.
// ----------------------------------------------------------------------------
module qpf_serial_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  qpf_pkg::unit_ctl_type ctl,
   input  logic [63:0]           opa,
   input  logic [63:0]           opb,
   output logic                  busy,
   output logic [63:0]           result
);
   import qpf_pkg::*;

   logic [63:0] acc_ff, acc_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [6:0]  cnt_ff, cnt_in;
   op_type      op_ff, op_in;
   logic        busy_ff, busy_in;
   logic [64:0] trial;
   logic [65:0] rem_sh;
   logic [65:0] sq_trial;

   // Next step of the running operation
   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      busy_in = busy_ff;
      trial    = '0;
      rem_sh   = '0;
      sq_trial = '0;
      if (ctl.start) begin
         op_in   = ctl.op;
         busy_in = 1'b1;
         acc_in  = '0;
         a_in    = opa;
         b_in    = opb;
         cnt_in  = (ctl.op == OP_SQRT) ? 7'd32 : 7'd64;
      end else if (busy_ff) begin
         case (op_ff)
            OP_MUL: begin
               // shift-add from the top bit of a
               acc_in = (acc_ff << 1) + (a_ff[63] ? b_ff : 64'd0);
               a_in   = a_ff << 1;
            end
            OP_DIV: begin
               // a: dividend shifting out, acc: remainder, quotient into a lsb
               rem_sh = {1'b0, acc_ff, a_ff[63]};
               trial  = rem_sh[64:0] - {1'b0, b_ff};
               a_in   = a_ff << 1;
               if (!trial[64]) begin
                  acc_in = trial[63:0];
                  a_in[0] = 1'b1;
               end else begin
                  acc_in = rem_sh[63:0];
               end
            end
            OP_SQRT: begin
               // b: root, acc: remainder, a: radicand two bits a step
               rem_sh   = {acc_ff, a_ff[63:62]};
               sq_trial = rem_sh - {b_ff, 2'b01};
               a_in     = a_ff << 2;
               if (!sq_trial[65]) begin
                  acc_in = sq_trial[63:0];
                  b_in   = {b_ff[62:0], 1'b1};
               end else begin
                  acc_in = rem_sh[63:0];
                  b_in   = {b_ff[62:0], 1'b0};
               end
            end
            default: ;
         endcase
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= OP_MUL;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      acc_ff <= (ctl.start && ctl.op == OP_SQRT) ? 64'd0 : acc_in;
      a_ff   <= a_in;
      b_ff   <= (ctl.start && ctl.op == OP_SQRT) ? 64'd0 : b_in;
   end

   assign busy = busy_ff;
   always_comb begin
      case (op_ff)
         OP_MUL:  result = acc_ff;
         OP_DIV:  result = a_ff;
         OP_SQRT: result = b_ff;
         default: result = acc_ff;
      endcase
   end

   // Unit counts down only while busy
   assert property (@(posedge clock) disable iff (reset)
      busy_ff && !ctl.start && cnt_ff != 7'd1 |=> busy_ff)
      else $error("serial unit stopped early");
   assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> busy_ff)
      else $error("serial unit did not start");
   assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> !$past(busy_ff) || $past(cnt_ff) == 7'd1 || $past(reset))
      else $error("serial unit ended without count");
endmodule

FILE: bench/tb_quintic_profile_follower_top.sv
// ----------------------------------------------------------------------------
// tb_quintic_profile_follower_top
// Self-checking bench for the quintic profile follower. A table of directed
// ticks comes first, then random well-formed moves mixed with noise ticks,
// under several gain settings. Every response is compared field by field with
// a profile predictor or a typed table entry. Both stream sides idle at random,
// and the response side holds off once long enough to stall the request side.
// ----------------------------------------------------------------------------
module tb_quintic_profile_follower_top;
   timeunit 1ns;
   timeprecision 1ps;
   import qpf_pkg::*;

   localparam int TICK_TARGET = 1750;
   localparam int IDLE_LIMIT  = 20000;
   localparam int STALL_LEN   = 3000;
   localparam longint unsigned FRAC_ONE = 64'd1 << FRAC_W;

   typedef struct packed {
      logic [DLT_W-1:0]         elapsed_delta;
      logic [TIME_W-1:0]        tolerance;
      logic [TIME_W-1:0]        move_duration;
      logic signed [POS_W-1:0]  final_pos;
      logic signed [POS_W-1:0]  current_pos;
   } tick_req_type;

   typedef struct packed {
      logic [6:0]               pad;
      logic signed [POS_W-1:0]  target_pos;
      logic                     done_res;
      logic signed [DRV_W-1:0]  drive;
   } tick_rsp_type;

   typedef struct {
      tick_req_type req;
      bit           typed;
      tick_rsp_type want;
   } dir_row_type;

   logic             clock;
   logic             reset;
   logic             csr_valid;
   logic             csr_ready;
   logic [GAIN_W-1:0] csr_data;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;

   // Profile follower state as the predictor sees it
   longint unsigned pf_gain;
   longint          pf_final;
   longint          pf_start;
   int unsigned     pf_duration;
   int unsigned     pf_tolerance;
   int unsigned     pf_elapsed;
   bit              pf_done;
   longint          last_target;

   tick_rsp_type expected_rsp_q[$];
   int        mismatch_count;
   int        rsp_seen;
   int        ticks_sent;
   int        idle_cycles;

   quintic_profile_follower_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Floor integer square root, bit by bit
   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // 3-4-5 polynomial of normalized time, Q1.16, clamped at one
   function automatic longint unsigned quintic_fraction(input int unsigned t,
                                                        input int unsigned dur);
      longint unsigned u, u2, u3, inner, p;
      if (dur == 0 || t >= dur) u = FRAC_ONE;
      else u = (longint'(t) << FRAC_W) / dur;
      u2 = (u * u) >> FRAC_W;
      u3 = (u2 * u) >> FRAC_W;
      inner = 10 * FRAC_ONE + 6 * u2 - 15 * u;
      p = (u3 * inner) >> FRAC_W;
      return (p > FRAC_ONE) ? FRAC_ONE : p;
   endfunction

   // Advance the follower state by one tick and form its response
   function automatic tick_rsp_type follow_tick(input tick_req_type t);
      longint          cp, fp, span, delta, tq, err, pos_gap, drv, tgt;
      longint unsigned p, m, part, mag, dm, adist;
      int unsigned     e;
      tick_rsp_type    r;
      cp = longint'(t.current_pos);
      fp = longint'(t.final_pos);
      drv = 0;
      tgt = pf_final;
      if (fp != pf_final) begin
         pf_final = fp;
         pf_start = cp;
         pf_duration = 32'(t.move_duration);
         pf_tolerance = 32'(t.tolerance);
         pf_elapsed = 0;
         pf_done = 1'b0;
      end else begin
         e = pf_elapsed + 32'(t.elapsed_delta);
         pf_elapsed = (e > 65535) ? 65535 : e;
      end
      if (!pf_done) begin
         p = quintic_fraction(pf_elapsed, pf_duration);
         span = pf_final - pf_start;
         m = (span < 0) ? -span : span;
         part = (((m >> 32) * p) << 24) + (((m & 64'hFFFF_FFFF) * p) >> 8);
         delta = (span < 0) ? -longint'(part) : longint'(part);
         tq = pf_start * 256 + delta;
         err = tq - cp * 256;
         mag = (err < 0) ? -err : err;
         dm = (pf_gain * floor_sqrt(mag)) >> 5;
         pos_gap = cp - pf_final;
         adist = (pos_gap < 0) ? -pos_gap : pos_gap;
         if (err > 0) drv = (dm > 32767) ? 32767 : longint'(dm);
         else if (err < 0) drv = (dm > 32768) ? -32768 : -longint'(dm);
         tgt = tq >>> 8;
         if (pf_elapsed >= pf_duration || adist < pf_tolerance) pf_done = 1'b1;
      end
      r = '0;
      r.drive = drv[15:0];
      r.done_res = pf_done;
      r.target_pos = tgt[31:0];
      last_target = tgt;
      return r;
   endfunction

   // Offer one tick after a gap, hold it until taken, then queue its response
   task automatic send_tick(input tick_req_type t, input bit typed,
                            input tick_rsp_type want);
      int           gap;
      tick_rsp_type r;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= t;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = follow_tick(t);
      expected_rsp_q.push_back(typed ? want : r);
      ticks_sent++;
   endtask

   // Let every response drain, then write the gain
   task automatic write_gain(input logic [GAIN_W-1:0] g);
      req_tvalid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= g;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      pf_gain = g;
   endtask

   // Directed ticks: extremes, tolerance finish, zero duration, done hold
   dir_row_type dir_rows[14] = '{
      '{'{8'd3, 16'd0, 16'd5, 32'sd0, 32'sd0}, 1'b1, '{7'd0, 32'sd0, 1'b1, 16'sd0}},
      '{'{8'd0, 16'd0, 16'd0, 32'sd0, 32'sd0}, 1'b1, '{7'd0, 32'sd0, 1'b1, 16'sd0}},
      '{'{8'd0, 16'd0, 16'd0, 32'sh7FFF_FFFF, 32'sh8000_0000}, 1'b1,
        '{7'd0, 32'sh7FFF_FFFF, 1'b1, 16'sh7FFF}},
      '{'{8'd0, 16'd0, 16'd0, 32'sh8000_0000, 32'sh7FFF_FFFF}, 1'b1,
        '{7'd0, 32'sh8000_0000, 1'b1, 16'sh8000}},
      '{'{8'd9, 16'd0, 16'd0, 32'sd1000, 32'sd1000}, 1'b1, '{7'd0, 32'sd1000, 1'b1, 16'sd0}},
      '{'{8'd0, 16'd0, 16'd100, 32'sd5000, 32'sd0}, 1'b0, '0},
      '{'{8'd25, 16'd0, 16'd100, 32'sd5000, 32'sd1000}, 1'b0, '0},
      '{'{8'd25, 16'd0, 16'd100, 32'sd5000, 32'sd2600}, 1'b0, '0},
      '{'{8'd255, 16'd0, 16'd100, 32'sd5000, 32'sd4000}, 1'b0, '0},
      '{'{8'd0, 16'd50, 16'd400, -32'sd3000, 32'sd0}, 1'b0, '0},
      '{'{8'd10, 16'd0, 16'd0, -32'sd3000, -32'sd2990}, 1'b0, '0},
      '{'{8'd255, 16'hFFFF, 16'hFFFF, -32'sd3000, 32'sd7}, 1'b1,
        '{7'd0, -32'sd3000, 1'b1, 16'sd0}},
      '{'{8'd255, 16'hFFFF, 16'hFFFF, 32'sd77, -32'sd77}, 1'b0, '0},
      '{'{8'd1, 16'd0, 16'hFFFF, -32'sd77, 32'sh7FFF_0000}, 1'b0, '0}
   };

   // Stimulus: directed table, then gain phases of random moves
   initial begin
      tick_req_type      t;
      logic [GAIN_W-1:0] gains[4];
      int                n;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      mismatch_count = 0;
      ticks_sent = 0;
      pf_gain = GAIN_RESET;
      pf_final = 0;
      pf_start = 0;
      pf_duration = 0;
      pf_tolerance = 0;
      pf_elapsed = 0;
      pf_done = 1'b0;
      last_target = 0;
      gains = '{16'd0, 16'hFFFF, 16'd0, GAIN_RESET};
      gains[2] = 16'($urandom_range(1, 65534));
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[i]) send_tick(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
      for (int ph = 0; ph < 4; ph++) begin
         write_gain(gains[ph]);
         // Long move that runs the elapsed count into saturation
         if (ph == 1) begin
            t.final_pos = $urandom;
            t.current_pos = $urandom;
            t.move_duration = 16'hFFFF;
            t.tolerance = 16'd0;
            t.elapsed_delta = 8'd255;
            for (int k = 0; k < 262; k++) send_tick(t, 1'b0, '0);
         end
         while (ticks_sent < (ph + 1) * TICK_TARGET / 4) begin
            if ($urandom_range(0, 7) < 6) begin
               // Well-formed move: new final, then ticks tracking the target
               t.final_pos = ($urandom_range(0, 3) == 0) ? $urandom
                             : $signed($urandom_range(0, 200000)) - 100000;
               t.current_pos = ($urandom_range(0, 3) == 0) ? $urandom
                               : $signed($urandom_range(0, 200000)) - 100000;
               t.move_duration = ($urandom_range(0, 15) == 0) ? 16'($urandom)
                                 : 16'($urandom_range(0, 400));
               t.tolerance = ($urandom_range(0, 15) == 0) ? 16'($urandom)
                             : 16'($urandom_range(0, 40));
               n = $urandom_range(1, 12);
               for (int k = 0; k < n; k++) begin
                  t.elapsed_delta = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                    : 8'($urandom_range(0, 60));
                  send_tick(t, 1'b0, '0);
                  t.current_pos = 32'(last_target + $signed($urandom_range(0, 400)) - 200);
                  t.move_duration = 16'($urandom);
                  t.tolerance = 16'($urandom);
               end
            end else begin
               t.current_pos = $urandom;
               t.final_pos = $urandom;
               t.move_duration = 16'($urandom);
               t.tolerance = 16'($urandom);
               t.elapsed_delta = 8'($urandom);
               send_tick(t, 1'b0, '0);
            end
         end
      end
      req_tvalid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
         $display("PASS quintic_profile_follower_top");
      end else begin
         $display("FAIL quintic_profile_follower_top");
      end
      $finish;
   end

   // Response side: random ready gaps, one long hold-off, field checks
   initial begin
      int           gap;
      tick_rsp_type got;
      tick_rsp_type want;
      rsp_tready = 1'b0;
      rsp_seen = 0;
      @(negedge reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         if (rsp_seen == 150) gap = STALL_LEN;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got = rsp_tdata;
         rsp_seen++;
         if (expected_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response %h", got);
         end else begin
            want = expected_rsp_q.pop_front();
            if (got.drive !== want.drive || got.done_res !== want.done_res ||
                got.target_pos !== want.target_pos || got.pad !== 7'd0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response %0d: drive %0d/%0d done %0d/%0d target %0d/%0d (exp/act)",
                           rsp_seen, want.drive, got.drive, want.done_res, got.done_res,
                           want.target_pos, got.target_pos);
            end
         end
      end
   end

   // Watchdog: end the run if no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL quintic_profile_follower_top");
            $finish;
         end
      end
   end
endmodule
